// ===== rtl/core/ptm_pkg.sv =====
// ----------------------------------------------------------------------------
// ptm_pkg
// Shared types and constants for the present timing monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package ptm_pkg;

  // Event codes carried in the func field.
  localparam logic [2:0] FN_ACQ_BEGIN = 3'd0;
  localparam logic [2:0] FN_ACQ_END   = 3'd1;
  localparam logic [2:0] FN_SUBMIT    = 3'd2;
  localparam logic [2:0] FN_FENCE     = 3'd3;
  localparam logic [2:0] FN_SYNC_WAIT = 3'd4;
  localparam logic [2:0] FN_PRESENT   = 3'd5;
  localparam logic [2:0] FN_CLEAR     = 3'd6;
  localparam logic [2:0] FN_READ      = 3'd7;

  // Configuration register indexes.
  localparam logic [1:0] REG_EXPECTED  = 2'd0;
  localparam logic [1:0] REG_TOLERANCE = 2'd1;
  localparam logic [1:0] REG_US_PER_TK = 2'd2;

  localparam logic [31:0] US_PER_TICK_RESET = 32'd223696213;

  // Event counter slots.
  localparam int NUM_COUNTERS = 7;
  localparam logic [2:0] CNT_ACQ     = 3'd0;
  localparam logic [2:0] CNT_SUBMIT  = 3'd1;
  localparam logic [2:0] CNT_FENCE   = 3'd2;
  localparam logic [2:0] CNT_SYNC    = 3'd3;
  localparam logic [2:0] CNT_PRESENT = 3'd4;
  localparam logic [2:0] CNT_FAULT   = 3'd5;
  localparam logic [2:0] CNT_OUTLIER = 3'd6;

  // Statistic slots.
  localparam int NUM_STATS = 5;
  localparam logic [2:0] ST_INTERVAL    = 3'd0;
  localparam logic [2:0] ST_ACQ_BLOCK   = 3'd1;
  localparam logic [2:0] ST_ACQ_TO_PRES = 3'd2;
  localparam logic [2:0] ST_SUB_TO_PRES = 3'd3;
  localparam logic [2:0] ST_SYNC        = 3'd4;

  // Read select map.
  localparam logic [6:0] SEL_HELD_MASK  = 7'd7;
  localparam logic [6:0] SEL_LAST_INDEX = 7'd8;
  localparam logic [6:0] SEL_STAT_BASE  = 7'd16;
  localparam logic [6:0] SEL_STAT_END   = 7'd36;
  localparam logic [6:0] SEL_HIST_BASE  = 7'd64;

  localparam logic [1:0] FLD_COUNT = 2'd0;
  localparam logic [1:0] FLD_SUM   = 2'd1;
  localparam logic [1:0] FLD_MIN   = 2'd2;
  localparam logic [1:0] FLD_MAX   = 2'd3;

  typedef struct packed {
    logic [2:0]         func;
    logic [63:0]        tick;
    logic [63:0]        start_tick;
    logic signed [31:0] tex_slot;
    logic [6:0]         read_select;
  } in_t;

  typedef struct packed {
    logic [63:0] read_data;
    logic [63:0] interval_us;
    logic        outlier_seen;
    logic        fault_seen;
  } out_t;

  typedef struct packed {
    logic [31:0] count;
    logic [63:0] sum;
    logic [63:0] min;
    logic [63:0] max;
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/present_timing_monitor_core.sv =====
// ----------------------------------------------------------------------------
// present_timing_monitor_core
// Frame-pipeline timing monitor: event counters, timing statistics,
// present-interval histogram, held-texture and backward-time fault checks and outlier count.
// ----------------------------------------------------------------------------
// The block takes one event word per clock cycle while the output is not stalled.
// An accepted word sits in an input register while the conversion multipliers,
// statistic updates and read selection work on it, and its result word is
// written to the output register once that register can take a word.
// Throughput is one word per cycle while not stalled; the output register
// lets a new word enter while the previous result waits to be taken. All state
// is in flip-flops and is ready straight after reset.
`default_nettype none

module present_timing_monitor_core
  import ptm_pkg::*;
#(
  parameter int HIST_BUCKETS    = 32,
  parameter int BUCKET_WIDTH_US = 1024,
  parameter int TRACKED_SLOTS   = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_t         in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_t             out_data,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int HB_W   = $clog2(HIST_BUCKETS);
  localparam int SLOT_W = (TRACKED_SLOTS > 1) ? $clog2(TRACKED_SLOTS) : 1;

  // Configuration registers.
  logic [31:0] expected_interval_us;
  logic [31:0] tolerance_us;
  logic [31:0] us_per_tick_q32;

  // Input register.
  in_t  item;
  logic item_valid;
  logic fire;

  // Monitor state.
  logic [31:0]              event_counters [NUM_COUNTERS];
  logic [31:0]              interval_histogram [HIST_BUCKETS];
  logic [TRACKED_SLOTS-1:0] held_mask;
  logic [31:0]              last_index_bits;
  logic [63:0]              last_present_time;
  logic [63:0]              last_acquire_start;
  logic [63:0]              last_acquire_finish;
  logic [63:0]              last_submit_time;
  logic                     acquire_pending;
  logic                     present_valid;
  logic                     finish_valid;
  logic                     submit_valid;
  stat_t                    stats [NUM_STATS];

  // Per-word decode and arithmetic.
  logic [2:0]               func;
  logic [63:0]              tk;
  logic [63:0]              delta_a;
  logic                     ok_a;
  logic [63:0]              us_a;
  logic [63:0]              us_b;
  logic [63:0]              us_c;
  logic                     ok_b;
  logic                     ok_c;
  logic                     is_present;
  logic                     ivl_ok;
  logic [NUM_STATS-1:0]     stat_add;
  logic [63:0]              stat_val [NUM_STATS];
  logic                     slot_ok;
  logic [SLOT_W-1:0]        slot;
  logic [TRACKED_SLOTS-1:0] slot_bit;
  logic                     fault_unheld;
  logic                     fault_back;
  logic [63:0]              expected_ext;
  logic [63:0]              dev;
  logic                     outlier;
  logic [HB_W-1:0]          bucket;
  logic [63:0]              read_word;
  logic [6:0]               stat_off;
  logic [2:0]               stat_sel;
  logic [HB_W-1:0]          hist_sel;
  out_t                     result;

  // Configuration writes; an unused index is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_interval_us <= '0;
      tolerance_us         <= '0;
      us_per_tick_q32      <= US_PER_TICK_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_EXPECTED:  expected_interval_us <= cfg_data;
        REG_TOLERANCE: tolerance_us         <= cfg_data;
        REG_US_PER_TK: us_per_tick_q32      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: the input register moves on whenever the output register can
  // take a word.
  assign fire     = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) item <= in_data;
  end

  assign func       = item.func;
  assign tk         = item.tick;
  assign is_present = (func == FN_PRESENT);

  // The shared converter serves the present interval, acquire block and
  // sync wait, which never occur on the same word.
  always_comb begin
    unique case (func)
      FN_ACQ_END: begin
        delta_a = tk - last_acquire_start;
        ok_a    = acquire_pending && (tk >= last_acquire_start);
      end
      FN_SYNC_WAIT: begin
        delta_a = tk - item.start_tick;
        ok_a    = (tk >= item.start_tick);
      end
      default: begin
        delta_a = tk - last_present_time;
        ok_a    = present_valid && (tk >= last_present_time);
      end
    endcase
  end

  ptm_to_us u_to_us_a (.delta(delta_a), .q(us_per_tick_q32), .us(us_a));
  ptm_to_us u_to_us_b (.delta(tk - last_acquire_finish), .q(us_per_tick_q32), .us(us_b));
  ptm_to_us u_to_us_c (.delta(tk - last_submit_time), .q(us_per_tick_q32), .us(us_c));

  assign ok_b   = finish_valid && (tk >= last_acquire_finish);
  assign ok_c   = submit_valid && (tk >= last_submit_time);
  assign ivl_ok = is_present && ok_a;

  // Statistic update strobes and values.
  always_comb begin
    stat_add                 = '0;
    stat_add[ST_INTERVAL]    = fire && ivl_ok;
    stat_add[ST_ACQ_BLOCK]   = fire && (func == FN_ACQ_END) && ok_a;
    stat_add[ST_SYNC]        = fire && (func == FN_SYNC_WAIT) && ok_a;
    stat_add[ST_ACQ_TO_PRES] = fire && is_present && ok_b;
    stat_add[ST_SUB_TO_PRES] = fire && is_present && ok_c;
    stat_val[ST_INTERVAL]    = us_a;
    stat_val[ST_ACQ_BLOCK]   = us_a;
    stat_val[ST_SYNC]        = us_a;
    stat_val[ST_ACQ_TO_PRES] = us_b;
    stat_val[ST_SUB_TO_PRES] = us_c;
  end

  for (genvar s = 0; s < NUM_STATS; s++) begin : g_stat
    ptm_stat u_stat (
      .clk   (clk),
      .rst   (rst),
      .clear (fire && (func == FN_CLEAR)),
      .add   (stat_add[s]),
      .value (stat_val[s]),
      .stat  (stats[s])
    );
  end

  // Texture slot tracking; negative indexes fail the sign-bit check and drop out.
  assign slot_ok      = (item.tex_slot < 32'(TRACKED_SLOTS)) && !item.tex_slot[31];
  assign slot         = item.tex_slot[SLOT_W-1:0];
  assign slot_bit     = TRACKED_SLOTS'(1) << slot;
  assign fault_unheld = is_present && slot_ok && ((held_mask & slot_bit) == '0);
  assign fault_back   = is_present && present_valid && !(tk >= last_present_time);

  // Outlier check on the deviation from the expected interval.
  assign expected_ext = {32'd0, expected_interval_us};
  assign dev          = (us_a > expected_ext) ? (us_a - expected_ext) : (expected_ext - us_a);
  assign outlier      = ivl_ok && (expected_interval_us != 32'd0) &&
                        (dev > {32'd0, tolerance_us});

  // Histogram bucket: highest bucket whose lower edge the interval reaches.
  always_comb begin
    bucket = '0;
    for (int b = 1; b < HIST_BUCKETS; b++) begin
      if (us_a >= 64'(b) * 64'(BUCKET_WIDTH_US)) bucket = HB_W'(b);
    end
  end

  // Event counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_COUNTERS; i++) event_counters[i] <= '0;
    end else if (fire) begin
      unique case (func)
        FN_ACQ_END:   event_counters[CNT_ACQ]    <= event_counters[CNT_ACQ] + 32'd1;
        FN_SUBMIT:    event_counters[CNT_SUBMIT] <= event_counters[CNT_SUBMIT] + 32'd1;
        FN_FENCE:     event_counters[CNT_FENCE]  <= event_counters[CNT_FENCE] + 32'd1;
        FN_SYNC_WAIT: event_counters[CNT_SYNC]   <= event_counters[CNT_SYNC] + 32'd1;
        FN_PRESENT: begin
          event_counters[CNT_PRESENT] <= event_counters[CNT_PRESENT] + 32'd1;
          event_counters[CNT_FAULT]   <= event_counters[CNT_FAULT] +
                                         32'(fault_unheld) + 32'(fault_back);
          if (outlier) event_counters[CNT_OUTLIER] <= event_counters[CNT_OUTLIER] + 32'd1;
        end
        FN_CLEAR: event_counters[CNT_OUTLIER] <= '0;
        default: ;
      endcase
    end
  end

  // Histogram bins, one counter cell each.
  always_ff @(posedge clk) begin
    for (int b = 0; b < HIST_BUCKETS; b++) begin
      if (rst || (fire && (func == FN_CLEAR))) begin
        interval_histogram[b] <= '0;
      end else if (fire && ivl_ok && (bucket == HB_W'(b))) begin
        interval_histogram[b] <= interval_histogram[b] + 32'd1;
      end
    end
  end

  // Held mask and last present index survive a clear.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_mask       <= '0;
      last_index_bits <= '0;
    end else if (fire && slot_ok && (func == FN_ACQ_END)) begin
      held_mask <= held_mask | slot_bit;
    end else if (fire && is_present) begin
      if (slot_ok) held_mask <= held_mask & ~slot_bit;
      last_index_bits <= item.tex_slot;
    end
  end

  // Timestamps and their valid flags.
  always_ff @(posedge clk) begin
    if (rst || (fire && (func == FN_CLEAR))) begin
      last_present_time   <= '0;
      last_acquire_start  <= '0;
      last_acquire_finish <= '0;
      last_submit_time    <= '0;
      acquire_pending     <= 1'b0;
      present_valid       <= 1'b0;
      finish_valid        <= 1'b0;
      submit_valid        <= 1'b0;
    end else if (fire) begin
      unique case (func)
        FN_ACQ_BEGIN: begin
          last_acquire_start <= tk;
          acquire_pending    <= 1'b1;
        end
        FN_ACQ_END: begin
          acquire_pending     <= 1'b0;
          last_acquire_finish <= tk;
          finish_valid        <= 1'b1;
        end
        FN_SUBMIT: begin
          last_submit_time <= tk;
          submit_valid     <= 1'b1;
        end
        FN_PRESENT: begin
          last_present_time <= tk;
          present_valid     <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Read selection.
  assign stat_off = item.read_select - SEL_STAT_BASE;
  assign stat_sel = stat_off[4:2];
  assign hist_sel = item.read_select[HB_W-1:0];

  always_comb begin
    read_word = '0;
    if (item.read_select < 7'(NUM_COUNTERS)) begin
      read_word = {32'd0, event_counters[item.read_select[2:0]]};
    end else if (item.read_select == SEL_HELD_MASK) begin
      read_word = 64'(held_mask);
    end else if (item.read_select == SEL_LAST_INDEX) begin
      read_word = {32'd0, last_index_bits};
    end else if ((item.read_select >= SEL_STAT_BASE) && (item.read_select < SEL_STAT_END)) begin
      unique case (stat_off[1:0])
        FLD_COUNT: read_word = {32'd0, stats[stat_sel].count};
        FLD_SUM:   read_word = stats[stat_sel].sum;
        FLD_MIN:   read_word = stats[stat_sel].min;
        FLD_MAX:   read_word = stats[stat_sel].max;
        default:   read_word = '0;
      endcase
    end else if ((item.read_select >= SEL_HIST_BASE) &&
                 (7'(item.read_select[5:0]) < 7'(HIST_BUCKETS))) begin
      read_word = {32'd0, interval_histogram[hist_sel]};
    end
  end

  // Result word.
  always_comb begin
    result.read_data    = (func == FN_READ) ? read_word : '0;
    result.interval_us  = ivl_ok ? us_a : '0;
    result.outlier_seen = outlier;
    result.fault_seen   = fault_unheld || fault_back;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) out_data <= result;
  end

endmodule

`default_nettype wire

// ===== rtl/core/ptm_to_us.sv =====
// ----------------------------------------------------------------------------
// ptm_to_us
// Converts a tick difference to microseconds with a Q32 reciprocal multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module ptm_to_us (
  input  wire logic [63:0] delta,
  input  wire logic [31:0] q,
  output logic      [63:0] us
);

  logic [63:0] hi_prod;
  logic [63:0] lo_prod;

  // Upper half scales directly; lower half keeps only its integer part.
  assign hi_prod = 64'(delta[63:32]) * 64'(q);
  assign lo_prod = 64'(delta[31:0]) * 64'(q);
  assign us      = hi_prod + {32'd0, lo_prod[63:32]};

endmodule

`default_nettype wire

// ===== rtl/core/ptm_stat.sv =====
// ----------------------------------------------------------------------------
// ptm_stat
// One min/max/sum/count statistic slot.
// ----------------------------------------------------------------------------
`default_nettype none

module ptm_stat
  import ptm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        clear,
  input  wire logic        add,
  input  wire logic [63:0] value,
  output stat_t            stat
);

  // A zero count restarts the extremes with the new sample.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      stat <= '0;
    end else if (add) begin
      if (stat.count == 32'd0) begin
        stat.min <= value;
        stat.max <= value;
      end else begin
        if (value < stat.min) stat.min <= value;
        if (value > stat.max) stat.max <= value;
      end
      stat.sum   <= stat.sum + value;
      stat.count <= stat.count + 32'd1;
    end
  end

endmodule

`default_nettype wire
